FILE: design/lrps_pkg.sv
package lrps_pkg;

    localparam int NUM_RELAYS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int MASK_W  = 8;
    localparam int TICKS_W = 16;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // register index, byte address = 4 * index
    localparam logic [2:0] REG_LATCHING_MASK    = 3'd0;
    localparam logic [2:0] REG_ACTIVE_HIGH_MASK = 3'd1;
    localparam logic [2:0] REG_PULSE_TICKS      = 3'd2;
    localparam logic [2:0] REG_WAIT_TICKS       = 3'd3;
    localparam logic [2:0] REG_ALLOW_OVERLAP    = 3'd4;

    localparam logic [MASK_W-1:0]  RST_LATCHING_MASK    = 8'd0;
    localparam logic [MASK_W-1:0]  RST_ACTIVE_HIGH_MASK = 8'd255;
    localparam logic [TICKS_W-1:0] RST_PULSE_TICKS      = 16'd50;
    localparam logic [TICKS_W-1:0] RST_WAIT_TICKS       = 16'd20;

    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

    typedef struct packed {
        logic       func;
        logic [2:0] relay_index;
        logic       on_value;
    } t_in;

    typedef struct packed {
        logic [MASK_W-1:0] on_pins;
        logic [MASK_W-1:0] off_pins;
        logic              pulse_busy;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

FILE: design/latching_relay_pulse_scheduler.sv
// Relay channel driver with timed pulses for latching (two-coil) relays.
// Input channel (i_in_valid / o_in_ready, payload i_in): a tick beat or a
// command beat that sets one channel on or off. Output channel
// (o_out_valid / i_out_ready, payload o_out): one beat per input beat with
// the on/off pin levels and the busy flag as they stand after that item.
// Write configuration over the APB port only while the block is idle; the block itself does not enforce it.
// The per-channel countdowns live in a synchronous RAM with one read and one
// write port. A tick walks the channels in ascending order, one
// read-modify-write per cycle, with the read of the next channel overlapping
// the write of the current.
// Command: the item passes through S_CMD and then S_EMIT, where its result is
// registered. Tick: the item passes through S_SCAN, which walks every channel,
// then S_EMIT; the length of the channel walk sets how long a tick takes.
// No input beat is taken while one is in work. A stalled receiver holds
// the block in its final step until the held result is taken; the output
// register lets the previous result wait while the next item is worked.
// Reset clears all flags, pins and the busy flag and loads the register
// defaults; the countdown RAM needs no clearing since an entry's value is only
// used once its running flag was set by a load.
module latching_relay_pulse_scheduler #(
    parameter int NUM_RELAYS  = lrps_pkg::NUM_RELAYS_DEF,
    parameter int COUNT_WIDTH = lrps_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lrps_pkg::t_in               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lrps_pkg::t_out              o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrps_pkg::APB_AW-1:0] paddr,
    input  logic [lrps_pkg::APB_DW-1:0] pwdata,
    output logic [lrps_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int IW = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
    localparam int PW = (NUM_RELAYS > lrps_pkg::MASK_W) ? NUM_RELAYS : lrps_pkg::MASK_W;
    localparam int SW = (COUNT_WIDTH > lrps_pkg::TICKS_W) ? COUNT_WIDTH : lrps_pkg::TICKS_W;
    localparam logic [SW-1:0] COUNT_MAX = SW'({COUNT_WIDTH{1'b1}});

    // configuration
    logic [lrps_pkg::MASK_W-1:0]  r_latching_mask;
    logic [lrps_pkg::MASK_W-1:0]  r_active_high_mask;
    logic [lrps_pkg::TICKS_W-1:0] r_pulse_ticks;
    logic [lrps_pkg::TICKS_W-1:0] r_wait_ticks;
    logic                         r_allow_overlap;

    // channel state
    logic [NUM_RELAYS-1:0] r_on,   n_on;
    logic [NUM_RELAYS-1:0] r_off,  n_off;
    logic [NUM_RELAYS-1:0] r_run,  n_run;
    logic [NUM_RELAYS-1:0] r_wait, n_wait;
    logic [NUM_RELAYS-1:0] r_pend, n_pend;
    logic                  r_av,   n_av;
    logic [IW-1:0]         r_ach,  n_ach;

    // countdown RAM
    logic [COUNT_WIDTH-1:0] r_countdown [NUM_RELAYS];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wd;

    lrps_pkg::t_state r_state, n_state;
    lrps_pkg::t_in    r_item;
    lrps_pkg::t_out   r_out;
    logic             r_out_valid;
    logic [IW-1:0]    r_chan;

    logic          in_accept;
    logic          emit_load;
    logic          last_chan;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic [IW-1:0] cur;
    logic          cmd_ok;
    logic          do_begin;
    logic          do_finish;
    logic [NUM_RELAYS-1:0] cur_bit;
    logic [PW-1:0] on_pad;
    logic [PW-1:0] off_pad;

    function automatic logic [COUNT_WIDTH-1:0] f_sat(input logic [lrps_pkg::TICKS_W-1:0] t);
        logic [SW-1:0] w;
        w = SW'(t);
        if (w > COUNT_MAX) begin
            w = COUNT_MAX;
        end
        return w[COUNT_WIDTH-1:0];
    endfunction

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            lrps_pkg::REG_LATCHING_MASK:    prdata = 32'(r_latching_mask);
            lrps_pkg::REG_ACTIVE_HIGH_MASK: prdata = 32'(r_active_high_mask);
            lrps_pkg::REG_PULSE_TICKS:      prdata = 32'(r_pulse_ticks);
            lrps_pkg::REG_WAIT_TICKS:       prdata = 32'(r_wait_ticks);
            lrps_pkg::REG_ALLOW_OVERLAP:    prdata = 32'(r_allow_overlap);
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latching_mask    <= lrps_pkg::RST_LATCHING_MASK;
            r_active_high_mask <= lrps_pkg::RST_ACTIVE_HIGH_MASK;
            r_pulse_ticks      <= lrps_pkg::RST_PULSE_TICKS;
            r_wait_ticks       <= lrps_pkg::RST_WAIT_TICKS;
            r_allow_overlap    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                lrps_pkg::REG_LATCHING_MASK:    r_latching_mask    <= pwdata[7:0];
                lrps_pkg::REG_ACTIVE_HIGH_MASK: r_active_high_mask <= pwdata[7:0];
                lrps_pkg::REG_PULSE_TICKS:      r_pulse_ticks      <= pwdata[15:0];
                lrps_pkg::REG_WAIT_TICKS:       r_wait_ticks       <= pwdata[15:0];
                lrps_pkg::REG_ALLOW_OVERLAP:    r_allow_overlap    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- control ----------------
    assign in_accept = i_in_valid && o_in_ready;
    assign last_chan = (r_chan == IW'(NUM_RELAYS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrps_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in.func == lrps_pkg::FUNC_COMMAND) ?
                              lrps_pkg::S_CMD : lrps_pkg::S_SCAN;
                end
            end
            lrps_pkg::S_CMD: n_state = lrps_pkg::S_EMIT;
            lrps_pkg::S_SCAN: begin
                if (last_chan) begin
                    n_state = lrps_pkg::S_EMIT;
                end
            end
            lrps_pkg::S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = lrps_pkg::S_IDLE;
                end
            end
            default: n_state = lrps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == lrps_pkg::S_IDLE);
        emit_load  = (r_state == lrps_pkg::S_EMIT) && (!r_out_valid || i_out_ready);
        rd_en      = (in_accept && (i_in.func == lrps_pkg::FUNC_TICK)) ||
                     ((r_state == lrps_pkg::S_SCAN) && !last_chan);
        rd_addr    = (r_state == lrps_pkg::S_SCAN) ? r_chan + IW'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in;
            r_chan <= '0;
        end else if (r_state == lrps_pkg::S_SCAN) begin
            r_chan <= r_chan + IW'(1);
        end
    end

    // ---------------- channel update ----------------
    assign cur     = (r_state == lrps_pkg::S_CMD) ? IW'(r_item.relay_index) : r_chan;
    assign cur_bit = NUM_RELAYS'(1) << cur;
    assign cmd_ok  = 32'(r_item.relay_index) < 32'(NUM_RELAYS);

    always_comb begin
        n_on      = r_on;
        n_off     = r_off;
        n_run     = r_run;
        n_wait    = r_wait;
        n_pend    = r_pend;
        n_av      = r_av;
        n_ach     = r_ach;
        mem_we    = 1'b0;
        mem_wd    = '0;
        do_begin  = 1'b0;
        do_finish = 1'b0;

        unique case (r_state)
            lrps_pkg::S_CMD: begin
                if (cmd_ok) begin
                    if (!r_latching_mask[r_item.relay_index]) begin
                        if (r_item.on_value) begin
                            n_on = n_on | cur_bit;
                        end else begin
                            n_on = n_on & ~cur_bit;
                        end
                    end else begin
                        do_finish = 1'b1;
                        do_begin  = 1'b1;
                        n_run     = n_run & ~cur_bit;
                        if (r_item.on_value) begin
                            n_pend = n_pend | cur_bit;
                        end else begin
                            n_pend = n_pend & ~cur_bit;
                        end
                    end
                end
            end
            lrps_pkg::S_SCAN: begin
                if (r_run[cur]) begin
                    if (r_rd_data > COUNT_WIDTH'(1)) begin
                        mem_we = 1'b1;
                        mem_wd = r_rd_data - COUNT_WIDTH'(1);
                    end else begin
                        // expired: a waiting channel retries, else the pulse ends
                        n_run = n_run & ~cur_bit;
                        if (r_wait[cur]) begin
                            do_begin = 1'b1;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (do_finish) begin
            n_on  = n_on & ~cur_bit;
            n_off = n_off & ~cur_bit;
            if (n_av && (n_ach == cur)) begin
                n_av = 1'b0;
            end
        end

        if (do_begin) begin
            mem_we = 1'b1;
            n_run  = n_run | cur_bit;
            if (!n_av || r_allow_overlap) begin
                if (n_pend[cur]) begin
                    n_on = n_on | cur_bit;
                end else begin
                    n_off = n_off | cur_bit;
                end
                n_av   = 1'b1;
                n_ach  = cur;
                n_wait = n_wait & ~cur_bit;
                mem_wd = f_sat(r_pulse_ticks);
            end else begin
                n_wait = n_wait | cur_bit;
                mem_wd = f_sat(r_wait_ticks);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on   <= '0;
            r_off  <= '0;
            r_run  <= '0;
            r_wait <= '0;
            r_pend <= '0;
            r_av   <= 1'b0;
            r_ach  <= '0;
        end else begin
            r_on   <= n_on;
            r_off  <= n_off;
            r_run  <= n_run;
            r_wait <= n_wait;
            r_pend <= n_pend;
            r_av   <= n_av;
            r_ach  <= n_ach;
        end
    end

    // scan reads channel c+1 while writing channel c, so addresses never collide
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_countdown[cur] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_countdown[rd_addr];
        end
    end

    // ---------------- result ----------------
    assign on_pad  = PW'(r_on);
    assign off_pad = PW'(r_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out.on_pins    <= on_pad[lrps_pkg::MASK_W-1:0] ^ ~r_active_high_mask;
            r_out.off_pins   <= off_pad[lrps_pkg::MASK_W-1:0] ^ ~r_active_high_mask;
            r_out.pulse_busy <= r_av;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: design/lrps_checker.sv
module lrps_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lrps_pkg::t_out o_out,
    input logic           pready
);

    // a held result keeps its beat until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result beat dropped or changed while stalled");

    // one item at a time: an accepted beat closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // a new result appears exactly when the block returns to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result loaded while still busy");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("reset did not leave the block idle and empty");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind latching_relay_pulse_scheduler lrps_checker u_lrps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .pready      (pready)
);
